// ===== sv/hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the HSV to RGB converter
// Word formats, hue sector codes and the fixed-point scaling constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] val_pct;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_out_t;

  // 60-degree hue sectors; the two unused codes fall into the last sector
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // classified word handed from front to back
  typedef struct packed {
    sector_e    sector;
    logic [5:0] k;      // 60 - |(H mod 120) - 60|, 0..60
    logic [6:0] sat;    // clipped to 0..100
    logic [6:0] val;    // clipped to 0..100
  } hsv_cls_t;

  localparam logic [8:0] HUE_FULL   = 9'd360;
  localparam logic [8:0] HUE_60     = 9'd60;
  localparam logic [8:0] HUE_120    = 9'd120;
  localparam logic [8:0] HUE_180    = 9'd180;
  localparam logic [8:0] HUE_240    = 9'd240;
  localparam logic [8:0] HUE_300    = 9'd300;
  localparam logic [5:0] SECTOR_DEG = 6'd60;
  localparam logic [6:0] PCT_FULL   = 7'd100;

  // Channels are in units of 1/600000. byte = floor(17*fix/40000)
  // = floor(floor(17*fix/64)/625); the divide by 625 is a reciprocal multiply
  // that is exact for the 18-bit range used here.
  localparam logic [4:0]  CHAN_MUL    = 5'd17;
  localparam int          PRE_SHIFT   = 6;
  localparam logic [17:0] RECIP_625   = 18'd214749;
  localparam int          RECIP_SHIFT = 27;

endpackage

// ===== sv/hsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front: input stage
// Accepts a word, wraps the hue, clips saturation and value, finds the hue
// sector and ramp weight, and holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module hsv_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hsv_pkg::hsv_in_t in_data_i,
  output logic             push_o,
  output hsv_pkg::hsv_cls_t push_data_o,
  input  logic             full_i
);
  import hsv_pkg::*;

  logic       valid_q, valid_d;
  hsv_cls_t   cls_q, cls_d;
  logic       accept;
  logic [8:0] hue_wrap;
  logic [8:0] base;
  logic [8:0] offs;
  logic [5:0] offs6;
  sector_e    sector;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    hue_wrap = (in_data_i.hue_deg >= HUE_FULL) ? in_data_i.hue_deg - HUE_FULL
                                               : in_data_i.hue_deg;
    if (hue_wrap < HUE_60) begin
      sector = SEC_RED_YEL; base = 9'd0;
    end else if (hue_wrap < HUE_120) begin
      sector = SEC_YEL_GRN; base = HUE_60;
    end else if (hue_wrap < HUE_180) begin
      sector = SEC_GRN_CYN; base = HUE_120;
    end else if (hue_wrap < HUE_240) begin
      sector = SEC_CYN_BLU; base = HUE_180;
    end else if (hue_wrap < HUE_300) begin
      sector = SEC_BLU_MAG; base = HUE_240;
    end else begin
      sector = SEC_MAG_RED; base = HUE_300;
    end
    offs  = hue_wrap - base;
    offs6 = offs[5:0];

    cls_d.sector = sector;
    // rising ramp in even sectors, falling in odd ones
    cls_d.k   = sector[0] ? SECTOR_DEG - offs6 : offs6;
    cls_d.sat = (in_data_i.sat_pct > PCT_FULL) ? PCT_FULL : in_data_i.sat_pct;
    cls_d.val = (in_data_i.val_pct > PCT_FULL) ? PCT_FULL : in_data_i.val_pct;
  end

  assign valid_d = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

  assign push_data_o = cls_q;

endmodule

// ===== sv/hsv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_queue: two-entry queue between front and back
// Lets the front keep taking words while the back is held by its receiver.
// ----------------------------------------------------------------------------
module hsv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsv_pkg::hsv_cls_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hsv_pkg::hsv_cls_t pop_data_o
);
  import hsv_pkg::*;

  hsv_cls_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/hsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_back: arithmetic pipeline
// Four stages: s*v and v*(100-s), then chroma / ramp / offset, then channel
// select and pre-scale, then the divide by 625 into the output register.
// ----------------------------------------------------------------------------
module hsv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  hsv_pkg::hsv_cls_t pop_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsv_pkg::hsv_out_t out_data_o
);
  import hsv_pkg::*;

  logic en;

  // stage 1
  logic       s1_valid_q;
  sector_e    s1_sector_q;
  logic [5:0] s1_k_q;
  logic [13:0] s1_sv_q, s1_sv_d;
  logic [13:0] s1_m0_q, s1_m0_d;

  // stage 2
  logic       s2_valid_q;
  sector_e    s2_sector_q;
  logic [19:0] s2_c_q, s2_c_d;
  logic [19:0] s2_x_q, s2_x_d;
  logic [19:0] s2_m_q, s2_m_d;

  // stage 3
  logic        s3_valid_q;
  logic [17:0] s3_n_q [3];
  logic [17:0] s3_n_d [3];
  logic [19:0] ch [3];
  logic [19:0] fix [3];
  logic [23:0] scaled [3];

  // output stage
  logic        out_valid_q;
  hsv_out_t    out_q, out_d;
  logic [35:0] prod [3];
  logic [7:0]  byte_v [3];

  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    s1_sv_d = 14'(pop_data_i.sat) * 14'(pop_data_i.val);
    s1_m0_d = 14'(pop_data_i.val) * 14'(PCT_FULL - pop_data_i.sat);

    s2_c_d = 20'(s1_sv_q) * 20'(SECTOR_DEG);
    s2_x_d = 20'(s1_sv_q) * 20'(s1_k_q);
    s2_m_d = 20'(s1_m0_q) * 20'(SECTOR_DEG);

    unique case (s2_sector_q)
      SEC_RED_YEL: begin ch[0] = s2_c_q; ch[1] = s2_x_q; ch[2] = '0;     end
      SEC_YEL_GRN: begin ch[0] = s2_x_q; ch[1] = s2_c_q; ch[2] = '0;     end
      SEC_GRN_CYN: begin ch[0] = '0;     ch[1] = s2_c_q; ch[2] = s2_x_q; end
      SEC_CYN_BLU: begin ch[0] = '0;     ch[1] = s2_x_q; ch[2] = s2_c_q; end
      SEC_BLU_MAG: begin ch[0] = s2_x_q; ch[1] = '0;     ch[2] = s2_c_q; end
      default:     begin ch[0] = s2_c_q; ch[1] = '0;     ch[2] = s2_x_q; end
    endcase

    for (int i = 0; i < 3; i++) begin
      fix[i]    = ch[i] + s2_m_q;
      scaled[i] = 24'(fix[i]) * 24'(CHAN_MUL);
      s3_n_d[i] = scaled[i][PRE_SHIFT +: 18];
      prod[i]   = 36'(s3_n_q[i]) * 36'(RECIP_625);
      byte_v[i] = prod[i][RECIP_SHIFT +: 8];
    end

    out_d.red   = byte_v[0];
    out_d.green = byte_v[1];
    out_d.blue  = byte_v[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= !empty_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sector_q <= pop_data_i.sector;
      s1_k_q      <= pop_data_i.k;
      s1_sv_q     <= s1_sv_d;
      s1_m0_q     <= s1_m0_d;
      s2_sector_q <= s1_sector_q;
      s2_c_q      <= s2_c_d;
      s2_x_q      <= s2_x_d;
      s2_m_q      <= s2_m_d;
      s3_n_q      <= s3_n_d;
      out_q       <= out_d;
    end
  end

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to 8-bit RGB colour conversion
// Hue in degrees (wrapped mod 360), saturation and value in percent
// (clipped at 100) in; truncated 8-bit red, green and blue out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with in_data_i. A word is taken
//   on a clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o / out_stall_i with out_data_o, one result
//   word per input word, in input order.
//   Throughput: one word per clock while the receiver keeps up.
//   An accepted word passes the front register, the queue and three back
//   stages into the output register.
//   The back pipeline advances as a whole when the output register is empty
//   or being taken.
//   When the receiver stalls, the back holds its words and the two-entry
//   queue plus the front register absorb up to three more; after that
//   in_stall_o rises. A stalled output word holds steady.
//   Reset clears all valid state; the block is ready the cycle after reset
//   is released.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsv_pkg::hsv_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsv_pkg::hsv_out_t out_data_o
);
  import hsv_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  hsv_cls_t push_data;
  hsv_cls_t pop_data;

  hsv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  hsv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  hsv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== bench/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb: self-checking bench for the HSV to RGB converter
// Walks a short table of hand-picked colors (hue wrap, sector edges, clipped
// saturation and value), then random words under random source gaps and sink
// stalls. Every output word is compared field by field, in input order, with
// a hand-entered value or a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  localparam int unsigned DEG_WRAP    = 360;
  localparam int unsigned SECTOR_SPAN = 60;
  localparam int unsigned PCT_MAX     = 100;
  localparam int unsigned FIX_ONE     = 600000;   // 100 * 100 * 60
  localparam int unsigned CHAN_SCALE  = 255;
  localparam int          RAND_WORDS  = 1630;
  localparam int          CALM_WORDS  = 250;
  localparam int          TAIL_CYCLES = 20;
  localparam int          STUCK_LIMIT = 2000;

  typedef struct {
    hsv_in_t  hsv;
    bit       typed;    // rgb below is hand-entered
    hsv_out_t rgb;
  } color_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  hsv_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  hsv_out_t out_data_o;

  // hand-entered expectation travels alongside the driven word
  bit       typed_ok;
  hsv_out_t typed_rgb;
  bit       calm;

  hsv_out_t   rgb_due[$];
  color_row_t color_plan[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;

  hsv_to_rgb_converter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] chan_byte(int unsigned fix);
    int unsigned q;
    q = (CHAN_SCALE * fix) / FIX_ONE;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic hsv_out_t rgb_of(hsv_in_t w);
    int unsigned h, s, v, hm, ramp_gap, k, c, x, m;
    int unsigned r, g, b;
    sector_e     sec;
    hsv_out_t    o;
    h = int'(w.hue_deg) % DEG_WRAP;
    s = (w.sat_pct > PCT_MAX) ? PCT_MAX : w.sat_pct;
    v = (w.val_pct > PCT_MAX) ? PCT_MAX : w.val_pct;
    hm = h % (2 * SECTOR_SPAN);
    ramp_gap = (hm >= SECTOR_SPAN) ? hm - SECTOR_SPAN : SECTOR_SPAN - hm;
    k = SECTOR_SPAN - ramp_gap;
    c = s * v * SECTOR_SPAN;
    x = s * v * k;
    m = v * (PCT_MAX - s) * SECTOR_SPAN;
    sec = sector_e'(h / SECTOR_SPAN);
    case (sec)
      SEC_RED_YEL: begin r = c; g = x; b = 0; end
      SEC_YEL_GRN: begin r = x; g = c; b = 0; end
      SEC_GRN_CYN: begin r = 0; g = c; b = x; end
      SEC_CYN_BLU: begin r = 0; g = x; b = c; end
      SEC_BLU_MAG: begin r = x; g = 0; b = c; end
      default:     begin r = c; g = 0; b = x; end
    endcase
    o.red   = chan_byte(r + m);
    o.green = chan_byte(g + m);
    o.blue  = chan_byte(b + m);
    return o;
  endfunction

  function automatic color_row_t color_row(int hue, int sat, int val, bit typed,
                                           int r = 0, int g = 0, int b = 0);
    color_row_t row;
    row.hsv.hue_deg = hue[8:0];
    row.hsv.sat_pct = sat[6:0];
    row.hsv.val_pct = val[6:0];
    row.typed       = typed;
    row.rgb.red     = r[7:0];
    row.rgb.green   = g[7:0];
    row.rgb.blue    = b[7:0];
    return row;
  endfunction

  // scoreboard and stuck counter
  always @(posedge clk_i) begin : score
    hsv_out_t want;
    if (in_valid_i && !in_stall_o)
      rgb_due.push_back(typed_ok ? typed_rgb : rgb_of(in_data_i));
    if (out_valid_o && !out_stall_i) begin
      if (rgb_due.size() == 0) begin
        $error("output word %h with no input word pending", out_data_o);
        mismatches++;
      end else begin
        want = rgb_due.pop_front();
        if (out_data_o.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_data_o.red);
          mismatches++;
        end
        if (out_data_o.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_data_o.green);
          mismatches++;
        end
        if (out_data_o.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_data_o.blue);
          mismatches++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // sink: random stall bursts, none once the run goes calm
  initial begin
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // source
  initial begin
    hsv_in_t w;
    bit      t_ok;
    hsv_out_t t_rgb;
    int      total;
    int      pick;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    typed_ok   = 1'b0;
    typed_rgb  = '0;
    calm       = 1'b0;

    color_plan.push_back(color_row(  0,   0,   0, 1,   0,   0,   0));
    color_plan.push_back(color_row(  0, 100, 100, 1, 255,   0,   0));
    color_plan.push_back(color_row( 60, 100, 100, 1, 255, 255,   0));
    color_plan.push_back(color_row(120, 100, 100, 1,   0, 255,   0));
    color_plan.push_back(color_row(180, 100, 100, 1,   0, 255, 255));
    color_plan.push_back(color_row(240, 100, 100, 1,   0,   0, 255));
    color_plan.push_back(color_row(300, 100, 100, 1, 255,   0, 255));
    color_plan.push_back(color_row(359, 100, 100, 0));
    color_plan.push_back(color_row(360, 100, 100, 1, 255,   0,   0));   // wraps to 0
    color_plan.push_back(color_row(420, 100, 100, 1, 255, 255,   0));   // wraps to 60
    color_plan.push_back(color_row(511, 127, 127, 0));
    color_plan.push_back(color_row(  0,   0, 100, 1, 255, 255, 255));
    color_plan.push_back(color_row(  0, 127, 127, 1, 255,   0,   0));   // both clip
    color_plan.push_back(color_row(  0,   0, 127, 1, 255, 255, 255));
    color_plan.push_back(color_row(  0, 127,   0, 1,   0,   0,   0));
    color_plan.push_back(color_row(  0, 101, 101, 1, 255,   0,   0));
    color_plan.push_back(color_row(  0, 100,  50, 1, 127,   0,   0));
    color_plan.push_back(color_row( 30, 100, 100, 0));
    color_plan.push_back(color_row( 59, 100, 100, 0));
    color_plan.push_back(color_row( 61, 100, 100, 0));
    color_plan.push_back(color_row(200,  50,  80, 0));
    color_plan.push_back(color_row(330,  73,  41, 0));
    color_plan.push_back(color_row(256,  64,  64, 0));

    total = color_plan.size() + RAND_WORDS;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < total; n++) begin
      if (n < color_plan.size()) begin
        w     = color_plan[n].hsv;
        t_ok  = color_plan[n].typed;
        t_rgb = color_plan[n].rgb;
      end else begin
        pick  = $urandom_range(0, 9);
        t_ok  = 1'b0;
        t_rgb = '0;
        if (pick < 7) begin
          w.hue_deg = 9'($urandom_range(0, 359));
          w.sat_pct = 7'($urandom_range(0, 100));
          w.val_pct = 7'($urandom_range(0, 100));
        end else if (pick == 7) begin
          // sector edges, including wrapped ones
          w.hue_deg = 9'(60 * $urandom_range(0, 8));
          w.sat_pct = 7'($urandom_range(0, 127));
          w.val_pct = 7'($urandom_range(0, 127));
        end else begin
          w.hue_deg = 9'($urandom_range(0, 511));
          w.sat_pct = 7'($urandom_range(0, 127));
          w.val_pct = 7'($urandom_range(0, 127));
        end
      end
      if (n == total - CALM_WORDS)
        calm = 1'b1;

      if (n == color_plan.size() + RAND_WORDS / 2) begin
        // hold off until the pipe has drained completely
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (rgb_due.size() != 0) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end

      in_valid_i <= 1'b1;
      in_data_i  <= w;
      typed_ok   <= t_ok;
      typed_rgb  <= t_rgb;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rgb_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (rgb_due.size() != 0) begin
      $error("%0d result words never arrived", rgb_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
